// ----- hw/rtl/wsp_pkg.sv -----
// ----------------------------------------------------------------------------
// wsp_pkg: shared types and constants for the wikilink span parser
// Transaction payload structs, scan state encoding and the special bytes
// that the parser looks for.
// ----------------------------------------------------------------------------
package wsp_pkg;

    // Counter widths
    localparam int unsigned POSITION_BITS = 32;
    localparam int unsigned OFFSET_BITS   = 16;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    // Special bytes
    localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
    localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'
    localparam logic [7:0] CH_PIPE  = 8'h7C;  // '|'
    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_CARET = 8'h5E;  // '^'

    // Scan state
    typedef enum logic [1:0] {
        SCAN_IDLE     = 2'd0,
        SCAN_ONE_OPEN = 2'd1,
        SCAN_LINK     = 2'd2,
        SCAN_CLOSE    = 2'd3
    } scan_mode_t;

    // One text byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } text_t;

    // One link found in the text
    typedef struct packed {
        logic [POSITION_BITS-1:0] inner_start;
        logic [OFFSET_BITS-1:0]   inner_length;
        logic                     pipe_found;
        logic [OFFSET_BITS-1:0]   pipe_offset;
        logic                     hash_found;
        logic [OFFSET_BITS-1:0]   hash_offset;
        logic                     is_block_ref;
        logic                     too_long;
    } link_t;

endpackage

// ----- hw/rtl/wikilink_span_parser.sv -----
// ----------------------------------------------------------------------------
// wikilink_span_parser: double-bracket link finder over a byte stream
// Scans text one byte per transaction and reports each non-empty [[...]]
// link as offsets: inner start, length, first pipe, first anchor hash and
// whether the anchor is a block reference.
// ----------------------------------------------------------------------------
// Usage:
//   text channel (text_valid/text_ready/text) carries one byte per
//   transaction; text.end_of_text marks the last byte, after which all scan
//   state and the byte position return to their reset values.
//   link channel (link_valid/link_ready/link) carries one transaction per
//   closed, non-empty link.
//   The registered link is valid in the cycle after its second ']' is taken.
//   Throughput: one byte per cycle unless stalled. The scan state updates
//   in the accept cycle; a single output register holds the pending link.
//   Stall: text_ready stays high while the output register is empty or is
//   being drained; it drops only while a link waits and link_ready is low.
//   Reset: rst_n clears the scan state, the byte position and link_valid.
//   Lengths and offsets saturate at the all-ones value and set too_long;
//   the byte position wraps.
// ----------------------------------------------------------------------------
module wikilink_span_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           text_valid,
    output logic           text_ready,
    input  wsp_pkg::text_t text,
    output logic           link_valid,
    input  logic           link_ready,
    output wsp_pkg::link_t link
);
    import wsp_pkg::*;

    // Scan state
    scan_mode_t               mode_reg, mode_next;
    logic [POSITION_BITS-1:0] byte_pos_reg, byte_pos_next;
    logic [POSITION_BITS-1:0] link_start_reg, link_start_next;
    logic [OFFSET_BITS-1:0]   inner_count_reg, inner_count_next;
    logic                     overflow_reg, overflow_next;
    logic                     pipe_seen_reg, pipe_seen_next;
    logic [OFFSET_BITS-1:0]   pipe_pos_reg, pipe_pos_next;
    logic                     hash_seen_reg, hash_seen_next;
    logic [OFFSET_BITS-1:0]   hash_pos_reg, hash_pos_next;
    logic                     check_caret_reg, check_caret_next;
    logic                     caret_seen_reg, caret_seen_next;

    // Output register
    logic  link_valid_reg, link_valid_next;
    link_t link_reg, link_result;
    logic  emit;

    logic       accept;
    logic [7:0] b;
    logic       is_open, is_close;

    assign text_ready = !link_valid_reg || link_ready;
    assign accept     = text_valid && text_ready;
    assign b          = text.data_byte;
    assign is_open    = (b == CH_OPEN);
    assign is_close   = (b == CH_CLOSE);

    // Next scan mode
    always_comb
    begin
        mode_next = mode_reg;
        case (mode_reg)
            SCAN_IDLE:
            begin
                mode_next = is_open ? SCAN_ONE_OPEN : SCAN_IDLE;
            end
            SCAN_ONE_OPEN:
            begin
                mode_next = is_open ? SCAN_LINK : SCAN_IDLE;
            end
            SCAN_LINK:
            begin
                if (is_open)
                    mode_next = SCAN_IDLE;
                else if (is_close)
                    mode_next = SCAN_CLOSE;
            end
            SCAN_CLOSE:
            begin
                // A lone ']' aborts; rescan this byte from idle
                if (is_close)
                    mode_next = SCAN_IDLE;
                else
                    mode_next = is_open ? SCAN_ONE_OPEN : SCAN_IDLE;
            end
            default:
            begin
                mode_next = SCAN_IDLE;
            end
        endcase
        if (text.end_of_text)
            mode_next = SCAN_IDLE;
    end

    // Link bookkeeping and result
    always_comb
    begin
        byte_pos_next    = byte_pos_reg + POSITION_BITS'(1);
        link_start_next  = link_start_reg;
        inner_count_next = inner_count_reg;
        overflow_next    = overflow_reg;
        pipe_seen_next   = pipe_seen_reg;
        pipe_pos_next    = pipe_pos_reg;
        hash_seen_next   = hash_seen_reg;
        hash_pos_next    = hash_pos_reg;
        check_caret_next = check_caret_reg;
        caret_seen_next  = caret_seen_reg;
        emit             = 1'b0;

        case (mode_reg)
            SCAN_ONE_OPEN:
            begin
                // Open a link: start after the second '['
                if (is_open)
                begin
                    link_start_next  = byte_pos_reg + POSITION_BITS'(1);
                    inner_count_next = '0;
                    overflow_next    = 1'b0;
                    pipe_seen_next   = 1'b0;
                    pipe_pos_next    = '0;
                    hash_seen_next   = 1'b0;
                    hash_pos_next    = '0;
                    check_caret_next = 1'b0;
                    caret_seen_next  = 1'b0;
                end
            end
            SCAN_LINK:
            begin
                if (!is_open && !is_close)
                begin
                    // Byte right after the anchor hash decides block reference
                    if (check_caret_reg)
                    begin
                        caret_seen_next  = (b == CH_CARET);
                        check_caret_next = 1'b0;
                    end
                    if (b == CH_PIPE && !pipe_seen_reg)
                    begin
                        pipe_seen_next = 1'b1;
                        pipe_pos_next  = inner_count_reg;
                    end
                    else if (b == CH_HASH && !pipe_seen_reg && !hash_seen_reg)
                    begin
                        hash_seen_next   = 1'b1;
                        hash_pos_next    = inner_count_reg;
                        check_caret_next = 1'b1;
                    end
                    // Saturate the inner count
                    if (inner_count_reg == OFFSET_MAX)
                        overflow_next = 1'b1;
                    else
                        inner_count_next = inner_count_reg + OFFSET_BITS'(1);
                end
            end
            SCAN_CLOSE:
            begin
                emit = is_close && (inner_count_reg != '0);
            end
            default:
            begin
            end
        endcase

        // Drop all state after the last byte
        if (text.end_of_text)
        begin
            byte_pos_next    = '0;
            link_start_next  = '0;
            inner_count_next = '0;
            overflow_next    = 1'b0;
            pipe_seen_next   = 1'b0;
            pipe_pos_next    = '0;
            hash_seen_next   = 1'b0;
            hash_pos_next    = '0;
            check_caret_next = 1'b0;
            caret_seen_next  = 1'b0;
        end

        link_result.inner_start  = link_start_reg;
        link_result.inner_length = inner_count_reg;
        link_result.pipe_found   = pipe_seen_reg;
        link_result.pipe_offset  = pipe_seen_reg ? pipe_pos_reg : '0;
        link_result.hash_found   = hash_seen_reg;
        link_result.hash_offset  = hash_seen_reg ? hash_pos_reg : '0;
        link_result.is_block_ref = hash_seen_reg && caret_seen_reg;
        link_result.too_long     = overflow_reg;
    end

    // Output valid: set on a new link, clear when taken
    always_comb
    begin
        link_valid_next = link_valid_reg && !link_ready;
        if (accept && emit)
            link_valid_next = 1'b1;
    end

    // Advance scan state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= SCAN_IDLE;
            byte_pos_reg    <= '0;
            link_start_reg  <= '0;
            inner_count_reg <= '0;
            overflow_reg    <= 1'b0;
            pipe_seen_reg   <= 1'b0;
            pipe_pos_reg    <= '0;
            hash_seen_reg   <= 1'b0;
            hash_pos_reg    <= '0;
            check_caret_reg <= 1'b0;
            caret_seen_reg  <= 1'b0;
            link_valid_reg  <= 1'b0;
        end
        else
        begin
            link_valid_reg <= link_valid_next;
            if (accept)
            begin
                mode_reg        <= mode_next;
                byte_pos_reg    <= byte_pos_next;
                link_start_reg  <= link_start_next;
                inner_count_reg <= inner_count_next;
                overflow_reg    <= overflow_next;
                pipe_seen_reg   <= pipe_seen_next;
                pipe_pos_reg    <= pipe_pos_next;
                hash_seen_reg   <= hash_seen_next;
                hash_pos_reg    <= hash_pos_next;
                check_caret_reg <= check_caret_next;
                caret_seen_reg  <= caret_seen_next;
            end
        end
    end

    // Hold the result payload until the next link
    always_ff @(posedge clk)
    begin
        if (accept && emit)
            link_reg <= link_result;
    end

    assign link_valid = link_valid_reg;
    assign link       = link_reg;

    // Checks
    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        link_valid |-> (link.inner_length != '0))
        else $error("empty link reported");

    a_block_ref: assert property (@(posedge clk) disable iff (!rst_n)
        link_valid |-> (!link.is_block_ref || link.hash_found))
        else $error("block reference without anchor hash");

    a_hash_before_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (link_valid && link.hash_found && link.pipe_found)
            |-> (link.hash_offset <= link.pipe_offset))
        else $error("anchor hash not before pipe");

    a_end_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && text.end_of_text)
            |=> (mode_reg == SCAN_IDLE && byte_pos_reg == '0 && inner_count_reg == '0))
        else $error("state not cleared after end of text");

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for wikilink_span_parser
// Streams short directed texts, then random texts until 700 bytes are sent, through
// the text channel with random gaps and link_ready stalls. An in-bench copy
// of the scan logic predicts every link, and each link transaction is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import wsp_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    class link_tracker;

        link_t      pending_links[$];
        int         errors;

        scan_mode_t                 mode;
        logic [POSITION_BITS-1:0]   pos;
        logic [POSITION_BITS-1:0]   start;
        logic [OFFSET_BITS-1:0]     count;
        logic [OFFSET_BITS-1:0]     pipe_pos;
        logic [OFFSET_BITS-1:0]     hash_pos;
        bit                         overflow;
        bit                         pipe_seen;
        bit                         hash_seen;
        bit                         check_caret;
        bit                         caret_seen;

        function new();
            errors = 0;
            restart();
        endfunction

        function void clear_fields();
            count       = '0;
            pipe_pos    = '0;
            hash_pos    = '0;
            overflow    = 0;
            pipe_seen   = 0;
            hash_seen   = 0;
            check_caret = 0;
            caret_seen  = 0;
        endfunction

        function void restart();
            mode  = SCAN_IDLE;
            pos   = '0;
            start = '0;
            clear_fields();
        endfunction

        // Track pipe, anchor and caret for one byte inside a link
        function void inner_byte(logic [7:0] b);
            if (check_caret)
            begin
                caret_seen  = (b == CH_CARET);
                check_caret = 0;
            end
            if (b == CH_PIPE && !pipe_seen)
            begin
                pipe_seen = 1;
                pipe_pos  = count;
            end
            else if (b == CH_HASH && !pipe_seen && !hash_seen)
            begin
                hash_seen   = 1;
                hash_pos    = count;
                check_caret = 1;
            end
            if (count == OFFSET_MAX)
                overflow = 1;
            else
                count = count + 1'b1;
        endfunction

        // Advance the scan for one accepted text transaction
        function void scan_byte(text_t t);
            link_t l;
            case (mode)
                SCAN_IDLE:
                    mode = (t.data_byte == CH_OPEN) ? SCAN_ONE_OPEN : SCAN_IDLE;
                SCAN_ONE_OPEN:
                begin
                    if (t.data_byte == CH_OPEN)
                    begin
                        mode  = SCAN_LINK;
                        start = pos + 1'b1;
                        clear_fields();
                    end
                    else
                        mode = SCAN_IDLE;
                end
                SCAN_LINK:
                begin
                    if (t.data_byte == CH_OPEN)
                        mode = SCAN_IDLE;
                    else if (t.data_byte == CH_CLOSE)
                        mode = SCAN_CLOSE;
                    else
                        inner_byte(t.data_byte);
                end
                default:
                begin
                    if (t.data_byte == CH_CLOSE)
                    begin
                        mode = SCAN_IDLE;
                        if (count != 0)
                        begin
                            l.inner_start  = start;
                            l.inner_length = count;
                            l.pipe_found   = pipe_seen;
                            l.pipe_offset  = pipe_seen ? pipe_pos : '0;
                            l.hash_found   = hash_seen;
                            l.hash_offset  = hash_seen ? hash_pos : '0;
                            l.is_block_ref = hash_seen && caret_seen;
                            l.too_long     = overflow;
                            pending_links  = {pending_links, l};
                        end
                    end
                    else
                        // lone ']' aborts; rescan this byte from idle
                        mode = (t.data_byte == CH_OPEN) ? SCAN_ONE_OPEN : SCAN_IDLE;
                end
            endcase
            pos = pos + 1'b1;
            if (t.end_of_text)
                restart();
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task compare(string field, logic [63:0] got, logic [63:0] want,
                     logic [31:0] at);
            if (got !== want)
                report($sformatf("link at %0d: %s got %0h expected %0h",
                                 at, field, got, want));
        endtask

        // Check one accepted link transaction against the oldest prediction
        task check_link(link_t got);
            link_t want;
            if (pending_links.size() == 0)
                report($sformatf("unexpected link at %0d", got.inner_start));
            else
            begin
                want = pending_links.pop_front();
                compare("inner_start", 64'(got.inner_start),
                        64'(want.inner_start), want.inner_start);
                compare("inner_length", 64'(got.inner_length),
                        64'(want.inner_length), want.inner_start);
                compare("pipe_found", 64'(got.pipe_found),
                        64'(want.pipe_found), want.inner_start);
                compare("pipe_offset", 64'(got.pipe_offset),
                        64'(want.pipe_offset), want.inner_start);
                compare("hash_found", 64'(got.hash_found),
                        64'(want.hash_found), want.inner_start);
                compare("hash_offset", 64'(got.hash_offset),
                        64'(want.hash_offset), want.inner_start);
                compare("is_block_ref", 64'(got.is_block_ref),
                        64'(want.is_block_ref), want.inner_start);
                compare("too_long", 64'(got.too_long),
                        64'(want.too_long), want.inner_start);
            end
        endtask

    endclass

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_ITEMS = 700;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   text_valid;
    logic   text_ready;
    text_t  text;
    logic   link_valid;
    logic   link_ready;
    link_t  link;

    link_tracker sb;
    int          cycles = 0;
    int          bytes_sent;
    bit          no_idle;

    wikilink_span_parser u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text       (text),
        .link_valid (link_valid),
        .link_ready (link_ready),
        .link       (link)
    );

    // Clock: period 20
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** wikilink_span_parser: FAILED **");
            $finish;
        end
    end

    // Add one byte to the end of a text
    function automatic void append_byte(ref byte_q_t q, input logic [7:0] b);
        q = {q, b};
    endfunction

    // Pick a sender gap: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Drive one text transaction; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        text_t t;
        gap = pick_gap();
        t = '{data_byte: b, end_of_text: eot};
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_valid <= 1'b1;
        text       <= t;
        do
            @(posedge clk);
        while (!text_ready);
        sb.scan_byte(t);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Send a whole text, marking its last byte
    task automatic send_text(input byte_q_t bytes);
        for (int i = 0; i < bytes.size(); i++)
            send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // One byte of link content, heavy on the special characters
    function automatic logic [7:0] inner_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return CH_PIPE;
        if (r < 20)
            return CH_HASH;
        if (r < 30)
            return CH_CARET;
        if (r < 34)
            return CH_OPEN;
        if (r < 38)
            return CH_CLOSE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Random text: mostly well-formed links, some broken ones and noise
    function automatic byte_q_t random_text();
        byte_q_t q;
        int r;
        int n;
        q = {};
        repeat ($urandom_range(1, 6))
        begin
            r = $urandom_range(0, 99);
            n = $urandom_range(0, 12);
            if (r < 75)
            begin
                append_byte(q, CH_OPEN);
                append_byte(q, CH_OPEN);
                repeat (n) append_byte(q, inner_char());
                if (r < 60)
                begin
                    append_byte(q, CH_CLOSE);
                    append_byte(q, CH_CLOSE);
                end
                else if (r < 67)
                    append_byte(q, CH_CLOSE);
                else if (r < 71)
                    append_byte(q, CH_OPEN);
            end
            else if (r < 90)
                repeat (n / 2) append_byte(q, 8'($urandom_range(0, 255)));
            else
                repeat (n) append_byte(q, inner_char());
        end
        if (q.size() == 0)
            append_byte(q, 8'($urandom_range(0, 255)));
        return q;
    endfunction

    // Receiver: random link_ready stretches, some long stalls
    initial
    begin
        int hold;
        int r;
        link_ready = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    link_ready <= 1'b1;
                    hold = $urandom_range(1, 8);
                end
                else if (r < 95)
                begin
                    link_ready <= 1'b0;
                    hold = $urandom_range(1, 4);
                end
                else
                begin
                    link_ready <= 1'b0;
                    hold = $urandom_range(20, 40);
                end
            end
        end
    end

    // Check every accepted link transaction
    always @(posedge clk)
    begin
        if (rst_n && link_valid && link_ready)
            sb.check_link(link);
    end

    // Stimulus and end of run
    initial
    begin
        byte_q_t q;
        sb         = new();
        rst_n      = 1'b0;
        text_valid = 1'b0;
        text       = '0;
        no_idle    = 0;
        bytes_sent = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Full link with zero byte, anchor caret, pipe and 0xFF
        q = '{CH_OPEN, CH_OPEN, 8'h00, CH_HASH, CH_CARET, CH_PIPE, 8'hFF, CH_CLOSE, CH_CLOSE};
        send_text(q);
        // Triple bracket abort, then an empty link
        q = '{CH_OPEN, CH_OPEN, CH_OPEN, CH_OPEN, CH_OPEN, CH_CLOSE, CH_CLOSE};
        send_text(q);
        // Lone close aborts and its next byte reopens; anchor hash is last target byte
        q = '{CH_OPEN, CH_OPEN, 8'h61, CH_CLOSE, CH_OPEN, CH_OPEN, 8'h62, CH_HASH,
              CH_CLOSE, CH_CLOSE};
        send_text(q);
        // Link left open at end of text
        q = '{CH_OPEN, CH_OPEN, 8'h71};
        send_text(q);

        // Random texts, some of them without sender gaps
        while (bytes_sent < RANDOM_ITEMS)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            send_text(random_text());
        end
        text_valid <= 1'b0;

        // Drain, then allow for the output register latency
        while (sb.pending_links.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.errors == 0)
            $display("** wikilink_span_parser: PASSED **");
        else
            $display("** wikilink_span_parser: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/wsp_pkg.sv
hw/rtl/wikilink_span_parser.sv
sim/tb_top.sv
